// ===== rtl/avpi_pkg.sv =====
// ----------------------------------------------------------------------------
// avpi_pkg
// Shared types, widths and register codes for the vertical velocity and
// position integrator.
// ----------------------------------------------------------------------------
package avpi_pkg;

  localparam int ACCEL_W  = 16;
  localparam int HALL_W   = 16;
  localparam int TIME_W   = 32;
  localparam int VEL_W    = 32;
  localparam int POS_W    = 48;
  localparam int PER_W    = 24;
  localparam int LEVEL_W  = 15;
  localparam int SPEED_W  = 31;
  localparam int COUNT_W  = 16;
  localparam int DELAY_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // serial multiplier: signed multiplicand times unsigned period
  localparam int MCAND_W = VEL_W + 1;
  localparam int PROD_W  = MCAND_W + PER_W;
  localparam int MCNT_W  = $clog2(PER_W + 1);

  // rounding shifts of the two products
  localparam int STEP_SHIFT = 9;
  localparam int POS_SHIFT  = 25;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND_EN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND_THR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STATIC_COUNT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HALL_PRESENT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HALL_ABSENT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_STUCK_SPEED    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_STUCK_DELAY    = 3'd7;

  // register reset values
  localparam logic [PER_W-1:0]   RST_SAMPLE_PERIOD = 24'd16777;
  localparam logic               RST_DEADBAND_EN   = 1'b1;
  localparam logic [SPEED_W-1:0] RST_DEADBAND_THR  = 31'd0;
  localparam logic [COUNT_W-1:0] RST_STATIC_COUNT  = 16'd1000;
  localparam logic [LEVEL_W-1:0] RST_HALL_PRESENT  = 15'd250;
  localparam logic [LEVEL_W-1:0] RST_HALL_ABSENT   = 15'd100;
  localparam logic [SPEED_W-1:0] RST_STUCK_SPEED   = 31'd838861;
  localparam logic [DELAY_W-1:0] RST_STUCK_DELAY   = 16'd500;

  typedef struct packed {
    logic signed [ACCEL_W-1:0] accel_z;
    logic signed [HALL_W-1:0]  hall_level;
    logic [TIME_W-1:0]         time_ms;
  } in_item_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] velocity;
    logic signed [POS_W-1:0] position;
    logic                    is_static;
    logic                    stuck_alarm;
  } out_item_t;

  typedef struct packed {
    logic [PER_W-1:0]   sample_period;
    logic               deadband_enable;
    logic [SPEED_W-1:0] deadband_threshold;
    logic [COUNT_W-1:0] static_sample_count;
    logic [LEVEL_W-1:0] hall_present_level;
    logic [LEVEL_W-1:0] hall_absent_level;
    logic [SPEED_W-1:0] stuck_speed_limit;
    logic [DELAY_W-1:0] stuck_delay_ms;
  } cfg_t;

endpackage

// ===== rtl/avpi_mul.sv =====
// ----------------------------------------------------------------------------
// avpi_mul
// Radix-2 serial multiplier: signed multiplicand times unsigned sample
// period, one period bit per cycle, shift-right accumulator.
// ----------------------------------------------------------------------------
module avpi_mul (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [avpi_pkg::MCAND_W-1:0] mcand,
  input  logic [avpi_pkg::PER_W-1:0]         mplier,
  output logic                               busy,
  output logic [avpi_pkg::PROD_W-1:0]        product
);
  import avpi_pkg::*;

  logic [MCNT_W-1:0]         cnt;
  logic [PROD_W-1:0]         acc;
  logic signed [MCAND_W-1:0] mcand_reg;
  logic signed [MCAND_W:0]   upper;
  logic signed [MCAND_W:0]   addend;
  logic signed [MCAND_W:0]   part_sum;

  // low bits of acc hold the not yet consumed period bits
  always_comb begin
    upper    = $signed({acc[PROD_W-1], acc[PROD_W-1:PER_W]});
    addend   = acc[0] ? $signed({mcand_reg[MCAND_W-1], mcand_reg}) : '0;
    part_sum = upper + addend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= MCNT_W'(PER_W);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand_reg <= mcand;
      acc       <= {{MCAND_W{1'b0}}, mplier};
    end else if (cnt != '0) begin
      acc <= {part_sum, acc[PER_W-1:1]};
    end
  end

  assign busy    = (cnt != '0);
  assign product = acc;

endmodule

// ===== rtl/avpi_core.sv =====
// ----------------------------------------------------------------------------
// avpi_core
// Sequencer for one sample: velocity step, deadband, saturated velocity,
// position increment, static and stuck detection. Both products go
// through the shared serial multiplier.
// ----------------------------------------------------------------------------
module avpi_core (
  input  logic                 clk,
  input  logic                 rst,
  input  avpi_pkg::cfg_t       cfg,
  input  logic                 in_valid,
  input  avpi_pkg::in_item_t   in_item,
  output logic                 idle,
  output logic                 res_valid,
  input  logic                 res_ready,
  output avpi_pkg::out_item_t  res_item
);
  import avpi_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL1 = 4'd1;
  localparam logic [3:0] S_STEP = 4'd2;
  localparam logic [3:0] S_DB   = 4'd3;
  localparam logic [3:0] S_VEL  = 4'd4;
  localparam logic [3:0] S_VSUM = 4'd5;
  localparam logic [3:0] S_MUL2 = 4'd6;
  localparam logic [3:0] S_INC  = 4'd7;
  localparam logic [3:0] S_POS  = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};
  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic [PROD_W-1:0] STEP_HALF = PROD_W'(1) << (STEP_SHIFT - 1);
  localparam logic [PROD_W-1:0] POS_HALF  = PROD_W'(1) << (POS_SHIFT - 1);

  function automatic logic [VEL_W-1:0] mag(input logic signed [VEL_W-1:0] v);
    mag = v[VEL_W-1] ? (VEL_W'(0) - v) : v;
  endfunction

  logic [3:0] state;

  // stored state
  logic                      primed;
  logic signed [ACCEL_W-1:0] prev_accel;
  logic signed [VEL_W-1:0]   prev_vel;
  logic signed [POS_W-1:0]   pos_acc;
  logic signed [HALL_W-1:0]  prev_hall;
  logic [COUNT_W-1:0]        stable_count;
  logic                      static_flag;
  logic [TIME_W-1:0]         last_stop;

  // current item and intermediates
  logic signed [ACCEL_W-1:0] cur_accel;
  logic signed [HALL_W-1:0]  cur_hall;
  logic [TIME_W-1:0]         cur_time;
  logic signed [VEL_W-1:0]   step;
  logic signed [VEL_W-1:0]   vel;
  logic signed [VEL_W-1:0]   inc;
  logic signed [POS_W-1:0]   pos;
  logic                      stable;

  // multiplier hookup
  logic                      mul_start;
  logic signed [MCAND_W-1:0] mul_mcand;
  logic                      mul_busy;
  logic [PROD_W-1:0]         product;

  logic                      accept;
  logic signed [ACCEL_W:0]   accel_sum;
  logic signed [MCAND_W-1:0] vel_sum;
  logic [PROD_W-1:0]         step_round;
  logic [PROD_W-1:0]         pos_round;
  logic signed [VEL_W:0]     vel_raw;
  logic signed [POS_W:0]     pos_raw;
  logic [HALL_W:0]           hall_mag;
  logic signed [HALL_W+3:0]  hall_x;
  logic signed [HALL_W+3:0]  prev_x;
  logic signed [HALL_W+3:0]  hall_10;
  logic signed [HALL_W+3:0]  prev_7;
  logic signed [HALL_W+3:0]  prev_13;
  logic                      stable_calc;
  logic [COUNT_W-1:0]        count_next;
  logic                      go_static;
  logic [TIME_W-1:0]         since_stop;
  logic                      alarm;

  assign idle   = (state == S_IDLE);
  assign accept = idle && in_valid;

  always_comb begin
    accel_sum  = $signed({in_item.accel_z[ACCEL_W-1], in_item.accel_z})
               + $signed({prev_accel[ACCEL_W-1], prev_accel});
    vel_sum    = $signed({prev_vel[VEL_W-1], prev_vel}) + $signed({vel[VEL_W-1], vel});
    mul_start  = (accept && primed) || (state == S_VSUM);
    mul_mcand  = (state == S_VSUM) ? vel_sum : MCAND_W'(accel_sum);
    step_round = product + STEP_HALF;
    pos_round  = product + POS_HALF;
    vel_raw    = $signed({prev_vel[VEL_W-1], prev_vel}) + $signed({step[VEL_W-1], step});
    pos_raw    = $signed({pos_acc[POS_W-1], pos_acc}) + (POS_W+1)'(inc);
  end

  // hall stability, exact integer compares
  always_comb begin
    hall_mag = cur_hall[HALL_W-1] ? ((HALL_W+1)'(0) - {cur_hall[HALL_W-1], cur_hall})
                                  : {cur_hall[HALL_W-1], cur_hall};
    hall_x   = (HALL_W+4)'(cur_hall);
    prev_x   = (HALL_W+4)'(prev_hall);
    hall_10  = (hall_x <<< 3) + (hall_x <<< 1);
    prev_7   = (prev_x <<< 3) - prev_x;
    prev_13  = (prev_x <<< 3) + (prev_x <<< 2) + prev_x;
    stable_calc = (hall_mag >= (HALL_W+1)'(cfg.hall_present_level))
               && (hall_10 >= prev_7) && (hall_10 <= prev_13);
    count_next = (stable_count == '1) ? stable_count : stable_count + 1'b1;
    go_static  = stable && (count_next >= cfg.static_sample_count);
  end

  always_comb begin
    since_stop = cur_time - last_stop;
    alarm = (hall_mag <= (HALL_W+1)'(cfg.hall_absent_level))
         && (mag(prev_vel) <= VEL_W'(cfg.stuck_speed_limit))
         && (since_stop >= TIME_W'(cfg.stuck_delay_ms));
  end

  avpi_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (mul_mcand),
    .mplier  (cfg.sample_period),
    .busy    (mul_busy),
    .product (product)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      primed       <= 1'b0;
      prev_accel   <= '0;
      prev_vel     <= '0;
      pos_acc      <= '0;
      prev_hall    <= '0;
      stable_count <= '0;
      static_flag  <= 1'b0;
      last_stop    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (!primed) begin
              // first sample only primes the history
              primed     <= 1'b1;
              prev_accel <= in_item.accel_z;
              prev_hall  <= in_item.hall_level;
            end else begin
              state <= S_MUL1;
            end
          end
        end
        S_MUL1: begin
          if (!mul_busy) begin
            state <= S_STEP;
          end
        end
        S_STEP: state <= S_DB;
        S_DB:   state <= S_VEL;
        S_VEL:  state <= S_VSUM;
        S_VSUM: state <= S_MUL2;
        S_MUL2: begin
          if (!mul_busy) begin
            state <= S_INC;
          end
        end
        S_INC:  state <= S_POS;
        S_POS:  state <= S_FIN;
        S_FIN: begin
          pos_acc   <= pos;
          prev_hall <= cur_hall;
          if (stable) begin
            stable_count <= count_next;
          end else begin
            stable_count <= '0;
            static_flag  <= 1'b0;
          end
          if (go_static) begin
            if (!static_flag) begin
              last_stop <= cur_time;
            end
            static_flag <= 1'b1;
            prev_vel    <= '0;
            prev_accel  <= '0;
          end else begin
            prev_vel    <= vel;
            prev_accel  <= cur_accel;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_accel <= in_item.accel_z;
      cur_hall  <= in_item.hall_level;
      cur_time  <= in_item.time_ms;
    end
    if (state == S_STEP) begin
      step   <= $signed(step_round[STEP_SHIFT+VEL_W-1:STEP_SHIFT]);
      stable <= stable_calc;
    end
    if (state == S_DB) begin
      if (cfg.deadband_enable && (mag(step) < VEL_W'(cfg.deadband_threshold))) begin
        step <= '0;
      end
    end
    if (state == S_VEL) begin
      if (vel_raw[VEL_W] != vel_raw[VEL_W-1]) begin
        vel <= vel_raw[VEL_W] ? VEL_MIN : VEL_MAX;
      end else begin
        vel <= vel_raw[VEL_W-1:0];
      end
    end
    if (state == S_INC) begin
      inc <= $signed(pos_round[POS_SHIFT+VEL_W-1:POS_SHIFT]);
    end
    if (state == S_POS) begin
      if (pos_raw[POS_W] != pos_raw[POS_W-1]) begin
        pos <= pos_raw[POS_W] ? POS_MIN : POS_MAX;
      end else begin
        pos <= pos_raw[POS_W-1:0];
      end
    end
  end

  assign res_valid            = (state == S_OUT);
  assign res_item.velocity    = prev_vel;
  assign res_item.position    = pos_acc;
  assign res_item.is_static   = static_flag;
  assign res_item.stuck_alarm = alarm;

endmodule

// ===== rtl/accel_velocity_position_integrator.sv =====
// ----------------------------------------------------------------------------
// accel_velocity_position_integrator
// Trapezoidal velocity and position integrator with static and stuck
// detection, with configuration registers and an output register.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid / in_stall / in_data carry one sample (accel_z, hall_level,
//   time_ms). A sample is taken when in_valid is high and in_stall is low.
//   out_valid / out_stall / out_data carry one result (velocity, position,
//   is_static, stuck_alarm), taken when out_valid is high and out_stall low.
//   cfg_valid / cfg_ready / cfg_index / cfg_data write one register; the
//   port is always ready. Write registers only while the block is idle.
//   The first sample after reset primes the history and gives no result.
//   Every later sample gives one result; both products run through one
//   serial multiplier that consumes one bit of sample_period per cycle,
//   and that sets the latency. A new sample is not taken until the
//   sequencer has handed the last result to the output register.
//   The output register lets a new sample be taken while a result waits.
//   If the receiver stalls and the output register is still full when the
//   next result is ready, the sequencer holds and in_stall stays high.
//   Synchronous reset clears all history and loads register defaults.
// ----------------------------------------------------------------------------
module accel_velocity_position_integrator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  avpi_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output avpi_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [avpi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [avpi_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import avpi_pkg::*;

  cfg_t      cfg;
  logic      core_idle;
  logic      res_valid;
  logic      res_ready;
  out_item_t res_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_period       <= RST_SAMPLE_PERIOD;
      cfg.deadband_enable     <= RST_DEADBAND_EN;
      cfg.deadband_threshold  <= RST_DEADBAND_THR;
      cfg.static_sample_count <= RST_STATIC_COUNT;
      cfg.hall_present_level  <= RST_HALL_PRESENT;
      cfg.hall_absent_level   <= RST_HALL_ABSENT;
      cfg.stuck_speed_limit   <= RST_STUCK_SPEED;
      cfg.stuck_delay_ms      <= RST_STUCK_DELAY;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SAMPLE_PERIOD: cfg.sample_period       <= cfg_data[PER_W-1:0];
        CFG_DEADBAND_EN:   cfg.deadband_enable     <= cfg_data[0];
        CFG_DEADBAND_THR:  cfg.deadband_threshold  <= cfg_data[SPEED_W-1:0];
        CFG_STATIC_COUNT:  cfg.static_sample_count <= cfg_data[COUNT_W-1:0];
        CFG_HALL_PRESENT:  cfg.hall_present_level  <= cfg_data[LEVEL_W-1:0];
        CFG_HALL_ABSENT:   cfg.hall_absent_level   <= cfg_data[LEVEL_W-1:0];
        CFG_STUCK_SPEED:   cfg.stuck_speed_limit   <= cfg_data[SPEED_W-1:0];
        CFG_STUCK_DELAY:   cfg.stuck_delay_ms      <= cfg_data[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  avpi_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_item   (in_data),
    .idle      (core_idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

  assign in_stall  = !core_idle;
  assign res_ready = !out_valid || !out_stall;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data <= res_item;
    end
  end

endmodule

// ===== sim/accel_velocity_position_integrator_test.sv =====
// ----------------------------------------------------------------------------
// accel_velocity_position_integrator_test
// Drives acceleration / hall / timestamp samples into the integrator and
// checks every velocity, position, static and stuck result against a
// trapezoidal integration model kept in the test. Starts with directed
// samples at the field and register extremes, then runs phases of mostly random
// register settings with travel, floor-stop, stuck and noise sequences.
// Both the sender and the receiver insert random gaps.
// ----------------------------------------------------------------------------
module accel_velocity_position_integrator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import avpi_pkg::*;

  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 80;
  localparam int TAIL_CYCLES   = 120;
  localparam int QUIET_LIMIT   = 4000;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 92;
  localparam int MAX_PRINTED   = 100;

  localparam longint VEL_HI = 64'sh7FFF_FFFF;
  localparam longint VEL_LO = -64'sh8000_0000;
  localparam longint POS_HI = 64'sh7FFF_FFFF_FFFF;
  localparam longint POS_LO = -64'sh8000_0000_0000;

  class motion_tracker;
    cfg_t       regs;
    bit         primed;
    longint     last_accel;
    longint     last_vel;
    longint     pos_acc;
    longint     last_hall;
    bit [15:0]  stable_run;
    bit         at_floor;
    bit [31:0]  stop_ms;
    out_item_t  expected_motion[$];
    int         errors;

    function new();
      regs.sample_period       = RST_SAMPLE_PERIOD;
      regs.deadband_enable     = RST_DEADBAND_EN;
      regs.deadband_threshold  = RST_DEADBAND_THR;
      regs.static_sample_count = RST_STATIC_COUNT;
      regs.hall_present_level  = RST_HALL_PRESENT;
      regs.hall_absent_level   = RST_HALL_ABSENT;
      regs.stuck_speed_limit   = RST_STUCK_SPEED;
      regs.stuck_delay_ms      = RST_STUCK_DELAY;
      primed     = 1'b0;
      last_accel = 0;
      last_vel   = 0;
      pos_acc    = 0;
      last_hall  = 0;
      stable_run = '0;
      at_floor   = 1'b0;
      stop_ms    = '0;
      errors     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SAMPLE_PERIOD: regs.sample_period       = data[PER_W-1:0];
        CFG_DEADBAND_EN:   regs.deadband_enable     = data[0];
        CFG_DEADBAND_THR:  regs.deadband_threshold  = data[SPEED_W-1:0];
        CFG_STATIC_COUNT:  regs.static_sample_count = data[COUNT_W-1:0];
        CFG_HALL_PRESENT:  regs.hall_present_level  = data[LEVEL_W-1:0];
        CFG_HALL_ABSENT:   regs.hall_absent_level   = data[LEVEL_W-1:0];
        CFG_STUCK_SPEED:   regs.stuck_speed_limit   = data[SPEED_W-1:0];
        CFG_STUCK_DELAY:   regs.stuck_delay_ms      = data[DELAY_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_motion.size();
    endfunction

    function void integrate_sample(in_item_t s);
      longint    accel, hall, habs, period, step, vel, pos;
      longint    thr_lim, present, absent, speed_lim;
      bit        stable, alarm;
      bit [31:0] since;
      out_item_t motion;
      accel = $signed(s.accel_z);
      hall  = $signed(s.hall_level);
      if (!primed) begin
        // first sample only seeds the history
        last_accel = accel;
        last_hall  = hall;
        primed     = 1'b1;
        return;
      end
      period    = regs.sample_period;
      thr_lim   = regs.deadband_threshold;
      present   = regs.hall_present_level;
      absent    = regs.hall_absent_level;
      speed_lim = regs.stuck_speed_limit;

      // round half up, then shift
      step = ((last_accel + accel) * period + (64'sd1 <<< (STEP_SHIFT - 1))) >>> STEP_SHIFT;
      if (regs.deadband_enable && (step < 0 ? -step : step) < thr_lim) step = 0;
      vel = last_vel + step;
      if (vel > VEL_HI) vel = VEL_HI;
      if (vel < VEL_LO) vel = VEL_LO;

      pos = pos_acc +
            (((last_vel + vel) * period + (64'sd1 <<< (POS_SHIFT - 1))) >>> POS_SHIFT);
      if (pos > POS_HI) pos = POS_HI;
      if (pos < POS_LO) pos = POS_LO;
      pos_acc = pos;

      habs   = hall < 0 ? -hall : hall;
      stable = habs >= present && 10 * hall >= 7 * last_hall && 10 * hall <= 13 * last_hall;
      if (stable) begin
        if (stable_run != 16'hFFFF) stable_run++;
        if (stable_run >= regs.static_sample_count) begin
          if (!at_floor) stop_ms = s.time_ms;
          at_floor = 1'b1;
          vel      = 0;
          accel    = 0;
        end
      end else begin
        stable_run = '0;
        at_floor   = 1'b0;
      end
      last_hall  = hall;
      last_accel = accel;
      last_vel   = vel;

      since = s.time_ms - stop_ms;
      alarm = habs <= absent && (vel < 0 ? -vel : vel) <= speed_lim &&
              since >= regs.stuck_delay_ms;

      motion.velocity    = vel[VEL_W-1:0];
      motion.position    = pos[POS_W-1:0];
      motion.is_static   = at_floor;
      motion.stuck_alarm = alarm;
      expected_motion.push_back(motion);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("%0t mismatch: %s", $time, msg);
    endtask

    task check_result(out_item_t r);
      out_item_t want;
      if (expected_motion.size() == 0) begin
        report("result with no sample waiting");
        return;
      end
      want = expected_motion.pop_front();
      if (r.velocity !== want.velocity)
        report($sformatf("velocity %0d, expected %0d", r.velocity, want.velocity));
      if (r.position !== want.position)
        report($sformatf("position %0d, expected %0d", r.position, want.position));
      if (r.is_static !== want.is_static)
        report($sformatf("is_static %b, expected %b", r.is_static, want.is_static));
      if (r.stuck_alarm !== want.stuck_alarm)
        report($sformatf("stuck_alarm %b, expected %b", r.stuck_alarm, want.stuck_alarm));
    endtask
  endclass

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  motion_tracker chk;
  bit            steady_phase = 1'b0;
  logic [31:0]   cur_ms       = '0;
  int            stall_left   = 0;
  int            stall_mode   = 0;
  int            mode_left    = 0;

  accel_velocity_position_integrator DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver: stretches of no stalls, short stalls, and short plus long stalls
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(100, 1500);
    end else begin
      mode_left--;
    end
    if (stall_left > 0)
      stall_left--;
    else if (stall_mode != 0 && $urandom_range(0, 99) < 25)
      stall_left = (stall_mode == 2 && $urandom_range(0, 7) == 0) ?
                   $urandom_range(20, 150) : $urandom_range(1, 4);
    out_stall <= (stall_left != 0);
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) chk.check_result(out_data);
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
          (cfg_valid && cfg_ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("accel_velocity_position_integrator_test NOT OK");
    $finish;
  end

  function automatic int clamp16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 5);
    return $urandom_range(10, 120);
  endfunction

  task automatic feed(input int accel, input int hall, input logic [31:0] stamp);
    in_item_t s;
    int       gap;
    s.accel_z    = accel[15:0];
    s.hall_level = hall[15:0];
    s.time_ms    = stamp;
    in_data  <= s;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    chk.integrate_sample(s);
    @(negedge clk);
    if (!steady_phase && $urandom_range(0, 199) == 0) begin
      // hold off until everything in flight has come out
      in_valid <= 1'b0;
      while (chk.pending() != 0) @(posedge clk);
      @(negedge clk);
    end else begin
      gap = pick_gap();
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (chk.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    chk.set_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_regs(input cfg_t c);
    write_reg(CFG_SAMPLE_PERIOD, CFG_DATA_W'(c.sample_period));
    write_reg(CFG_DEADBAND_EN,   CFG_DATA_W'(c.deadband_enable));
    write_reg(CFG_DEADBAND_THR,  CFG_DATA_W'(c.deadband_threshold));
    write_reg(CFG_STATIC_COUNT,  CFG_DATA_W'(c.static_sample_count));
    write_reg(CFG_HALL_PRESENT,  CFG_DATA_W'(c.hall_present_level));
    write_reg(CFG_HALL_ABSENT,   CFG_DATA_W'(c.hall_absent_level));
    write_reg(CFG_STUCK_SPEED,   CFG_DATA_W'(c.stuck_speed_limit));
    write_reg(CFG_STUCK_DELAY,   CFG_DATA_W'(c.stuck_delay_ms));
  endtask

  function automatic cfg_t make_regs(input logic [PER_W-1:0]   period,
                                     input logic               db_en,
                                     input logic [SPEED_W-1:0] db_thr,
                                     input logic [COUNT_W-1:0] count,
                                     input logic [LEVEL_W-1:0] present,
                                     input logic [LEVEL_W-1:0] absent,
                                     input logic [SPEED_W-1:0] speed,
                                     input logic [DELAY_W-1:0] delay);
    cfg_t c;
    c.sample_period       = period;
    c.deadband_enable     = db_en;
    c.deadband_threshold  = db_thr;
    c.static_sample_count = count;
    c.hall_present_level  = present;
    c.hall_absent_level   = absent;
    c.stuck_speed_limit   = speed;
    c.stuck_delay_ms      = delay;
    return c;
  endfunction

  function automatic cfg_t random_regs();
    cfg_t c;
    case ($urandom_range(0, 4))
      0:       c.sample_period = '0;
      1:       c.sample_period = PER_W'(1);
      2:       c.sample_period = '1;
      3:       c.sample_period = RST_SAMPLE_PERIOD;
      default: c.sample_period = PER_W'($urandom_range(2, 200000));
    endcase
    c.deadband_enable = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0:       c.deadband_threshold = '0;
      1:       c.deadband_threshold = SPEED_W'($urandom_range(1, 65536));
      2:       c.deadband_threshold = '1;
      default: c.deadband_threshold = SPEED_W'($urandom());
    endcase
    case ($urandom_range(0, 5))
      0:       c.static_sample_count = '0;
      1:       c.static_sample_count = COUNT_W'(1);
      2:       c.static_sample_count = '1;
      default: c.static_sample_count = COUNT_W'($urandom_range(2, 20));
    endcase
    case ($urandom_range(0, 4))
      0:       c.hall_present_level = '0;
      1:       c.hall_present_level = '1;
      default: c.hall_present_level = LEVEL_W'($urandom_range(50, 2000));
    endcase
    case ($urandom_range(0, 4))
      0:       c.hall_absent_level = '0;
      1:       c.hall_absent_level = '1;
      default: c.hall_absent_level = LEVEL_W'($urandom_range(20, 300));
    endcase
    case ($urandom_range(0, 4))
      0:       c.stuck_speed_limit = '0;
      1:       c.stuck_speed_limit = '1;
      2:       c.stuck_speed_limit = RST_STUCK_SPEED;
      default: c.stuck_speed_limit = SPEED_W'($urandom_range(0, 1 << 26));
    endcase
    case ($urandom_range(0, 3))
      0:       c.stuck_delay_ms = '0;
      1:       c.stuck_delay_ms = '1;
      default: c.stuck_delay_ms = DELAY_W'($urandom_range(0, 600));
    endcase
    return c;
  endfunction

  // travel, floor stops (some with a glitch), stuck stretches and raw noise
  task automatic run_phase(input int n_items);
    int done_items, kind, len, k, accel, base, dev, hall, glitch;
    done_items = 0;
    while (done_items < n_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        len   = $urandom_range(5, 30);
        accel = int'($urandom_range(0, 2048)) - 1024;
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 9) == 0)
            accel = int'($urandom_range(0, 65535)) - 32768;
          else
            accel = clamp16(accel + int'($urandom_range(0, 64)) - 32);
          hall = int'($urandom_range(0, int'(chk.regs.hall_absent_level) + 30));
          if ($urandom_range(0, 1) == 1) hall = -hall;
          cur_ms += $urandom_range(1, 3);
          feed(accel, clamp16(hall), cur_ms);
        end
      end else if (kind < 75) begin
        base = int'(chk.regs.hall_present_level) + int'($urandom_range(0, 400));
        if (base > 32767) base = 32767;
        if ($urandom_range(0, 6) == 0) base = -base;
        dev = (base < 0 ? -base : base) / 20;
        len = int'(chk.regs.static_sample_count) + int'($urandom_range(0, 8));
        if (len > 40) len = 40;
        glitch = (kind >= 62) ? int'($urandom_range(0, len - 1)) : -1;
        for (k = 0; k < len; k++) begin
          hall = base + int'($urandom_range(0, 2 * dev)) - dev;
          if (k == glitch) hall = ($urandom_range(0, 1) == 1) ? hall * 2 : hall / 3;
          cur_ms += 1;
          feed(int'($urandom_range(0, 16)) - 8, clamp16(hall), cur_ms);
        end
      end else if (kind < 88) begin
        len = $urandom_range(5, 25);
        for (k = 0; k < len; k++) begin
          hall = int'($urandom_range(0, chk.regs.hall_absent_level));
          if ($urandom_range(0, 1) == 1) hall = -hall;
          cur_ms += $urandom_range(1, 60);
          feed(int'($urandom_range(0, 6)) - 3, hall, cur_ms);
        end
      end else begin
        len = $urandom_range(1, 4);
        for (k = 0; k < len; k++)
          feed(int'($urandom_range(0, 65535)) - 32768, int'($urandom_range(0, 65535)) - 32768,
               $urandom());
      end
      done_items += len;
    end
  endtask

  initial begin
    int   k, p;
    cfg_t phase_regs;
    chk = new();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: priming sample, then field extremes
    feed(256, 300, 0);
    feed(32767, 300, 1);
    feed(-32768, -32768, 2);
    feed(-32768, 32767, 3);
    feed(0, 0, 32'hFFFF_FFFF);
    feed(1, -1, 0);
    drain();

    // zero period, zero static count: a steady zero hall goes static at once
    program_regs(make_regs('0, 1'b1, '0, '0, '0, '0, '0, '0));
    feed(100, 0, 10);
    feed(100, 0, 11);
    feed(-200, 0, 12);
    feed(5, -40, 13);
    drain();

    // full period, no deadband: velocity runs into both rails
    program_regs(make_regs('1, 1'b0, '1, '1, '1, '1, '1, '1));
    for (k = 0; k < 4; k++) feed(32767, 0, 20 + k);
    for (k = 0; k < 5; k++) feed(-32768, 0, 30 + k);
    drain();

    // deadband wider than any step
    program_regs(make_regs(RST_SAMPLE_PERIOD, 1'b1, '1, RST_STATIC_COUNT, RST_HALL_PRESENT,
                           RST_HALL_ABSENT, RST_STUCK_SPEED, RST_STUCK_DELAY));
    feed(1000, 0, 40);
    feed(-3000, 0, 41);
    feed(32767, 0, 42);
    drain();

    for (p = 0; p < PHASES; p++) begin
      if (p == 1)
        phase_regs = make_regs('1, 1'b1, '1, '1, '1, '1, '1, '1);
      else if (p == 2)
        phase_regs = make_regs(PER_W'(1), 1'b0, '0, COUNT_W'(1), '0, '0, '0, '0);
      else
        phase_regs = random_regs();
      program_regs(phase_regs);
      steady_phase = ($urandom_range(0, 3) == 0);
      // let the timestamp wrap during one phase
      if (p == 5) cur_ms = 32'hFFFF_FF00;
      run_phase(PHASE_ITEMS);
      steady_phase = 1'b0;
      drain();
    end

    while (chk.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (chk.errors == 0)
      $display("accel_velocity_position_integrator_test OK");
    else
      $display("accel_velocity_position_integrator_test NOT OK");
    $finish;
  end

endmodule
